[src/hnco_pkg.sv]
package hnco_pkg;

    // default module parameters
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int PHASE_LUT_BITS_DEF = 10;
    localparam int MAX_BANDS_DEF      = 16;

    // configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_NUM_BANDS      = 2'd0,
        CFG_FRAME_LENGTH   = 2'd1,
        CFG_HOP_FRAMES     = 2'd2,
        CFG_BAND_HALF_STEP = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [4:0]         num_bands;
        logic [16:0]        frame_length;
        logic [15:0]        hop_frames;
        logic signed [31:0] band_half_step;
    } t_hop_cfg;

    localparam t_hop_cfg CFG_RESET = '{
        num_bands:      5'd4,
        frame_length:   17'd1024,
        hop_frames:     16'd200,
        band_half_step: 32'sd0
    };

    // frame counters
    localparam int          COUNT_BITS = 16;
    localparam logic [16:0] FRAME_MAX  = 17'd65536;

    // rotator
    localparam int          PHASE_BITS    = 32;
    localparam int          SINE_BITS     = 16;
    localparam int          SINE_FRAC     = 15;
    localparam logic [63:0] SINE_AMP      = 64'd32767;
    localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
    localparam int          TAYLOR_TERMS  = 10;
    localparam int          BAND_OUT_BITS = 4;

endpackage

[src/hnco_sine_rom.sv]
module hnco_sine_rom #(
    parameter int PHASE_LUT_BITS = hnco_pkg::PHASE_LUT_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rd_en,
    input  logic [PHASE_LUT_BITS-1:0]              i_addr,
    output logic signed [hnco_pkg::SINE_BITS-1:0]  o_sin,
    output logic signed [hnco_pkg::SINE_BITS-1:0]  o_cos
);
    import hnco_pkg::*;

    localparam int TAB_SIZE   = 1 << PHASE_LUT_BITS;
    localparam int QUARTER    = TAB_SIZE / 4;
    localparam int QUART_BITS = PHASE_LUT_BITS - 2;

    typedef logic signed [SINE_BITS-1:0] t_sine_tab [TAB_SIZE];

    // q30 taylor series, every step truncated
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] sum;
        logic [63:0] mag;
        int          n;
        sum = x;
        mag = x;
        for (n = 1; n <= TAYLOR_TERMS; n++) begin
            mag = (mag * x) >> 30;
            mag = (mag * x) >> 30;
            unique case (n)
                1:       mag = mag / 64'd6;
                2:       mag = mag / 64'd20;
                3:       mag = mag / 64'd42;
                4:       mag = mag / 64'd72;
                5:       mag = mag / 64'd110;
                6:       mag = mag / 64'd156;
                7:       mag = mag / 64'd210;
                8:       mag = mag / 64'd272;
                9:       mag = mag / 64'd342;
                default: mag = mag / 64'd420;
            endcase
            if (n % 2 == 1) begin
                sum = (sum >= mag) ? sum - mag : 64'd0;
            end else begin
                sum = sum + mag;
            end
        end
        return sum;
    endfunction

    // quarter-wave folding of one entry
    function automatic logic signed [SINE_BITS-1:0] sine_entry(input int idx);
        logic [63:0] k;
        logic [63:0] x;
        logic [63:0] s64;
        int          quad;
        int          rem;
        quad = idx >> QUART_BITS;
        rem  = idx & (QUARTER - 1);
        if (quad == 1 || quad == 3) begin
            k = 64'(QUARTER - rem);
        end else begin
            k = 64'(rem);
        end
        x   = (k * HALF_PI_Q30 + 64'(QUARTER / 2)) >> QUART_BITS;
        s64 = (sin_q30(x) * SINE_AMP + (64'd1 << 29)) >> 30;
        if (s64 > SINE_AMP) begin
            s64 = SINE_AMP;
        end
        if (quad >= 2) begin
            s64 = -s64;
        end
        return s64[SINE_BITS-1:0];
    endfunction

    function automatic t_sine_tab build_tab();
        t_sine_tab tab;
        int        i;
        for (i = 0; i < TAB_SIZE; i++) begin
            tab[i] = sine_entry(i);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_tab();

    logic [PHASE_LUT_BITS-1:0] cos_addr;

    assign cos_addr = i_addr + PHASE_LUT_BITS'(QUARTER);

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_sin <= SINE_TAB[i_addr];
            o_cos <= SINE_TAB[cos_addr];
        end
    end

endmodule

[src/hnco_hop_ctrl.sv]
module hnco_hop_ctrl #(
    parameter int PHASE_LUT_BITS = hnco_pkg::PHASE_LUT_BITS_DEF,
    parameter int MAX_BANDS      = hnco_pkg::MAX_BANDS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [hnco_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [hnco_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                 i_adv,
    output logic [PHASE_LUT_BITS-1:0]            o_lut_idx,
    output logic [$clog2(MAX_BANDS)-1:0]         o_band
);
    import hnco_pkg::*;

    localparam int BAND_BITS = $clog2(MAX_BANDS);
    localparam int NB_BITS   = BAND_BITS + 1;
    localparam int OFF_BITS  = BAND_BITS + 2;
    localparam int STEP_BITS = OFF_BITS + PHASE_BITS;

    t_hop_cfg                 r_cfg, n_cfg;
    logic [PHASE_BITS-1:0]    r_phase, n_phase;
    logic [PHASE_BITS-1:0]    r_step, n_step;
    logic [COUNT_BITS-1:0]    r_sample, n_sample;
    logic [COUNT_BITS-1:0]    r_frame, n_frame;
    logic [BAND_BITS-1:0]     r_band, n_band;

    logic [NB_BITS-1:0]       cur_nb;
    logic [NB_BITS-1:0]       next_nb;
    logic [NB_BITS-1:0]       next_nb_m1;
    logic [NB_BITS-1:0]       band_p1;
    logic [16:0]              fl_eff;
    logic [16:0]              fl_m1;
    logic signed [OFF_BITS-1:0]  offset;
    logic signed [STEP_BITS-1:0] step_prod;

    // zero acts as one, anything above the band limit as the limit
    function automatic logic [NB_BITS-1:0] eff_bands(input logic [4:0] nb_raw);
        logic [31:0] w;
        w = 32'(nb_raw);
        if (w == 32'd0) begin
            w = 32'd1;
        end else if (w > 32'(MAX_BANDS)) begin
            w = 32'(MAX_BANDS);
        end
        return w[NB_BITS-1:0];
    endfunction

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_NUM_BANDS:      n_cfg.num_bands      = i_cfg_data[4:0];
                CFG_FRAME_LENGTH:   n_cfg.frame_length   = i_cfg_data[16:0];
                CFG_HOP_FRAMES:     n_cfg.hop_frames     = i_cfg_data[15:0];
                CFG_BAND_HALF_STEP: n_cfg.band_half_step = signed'(i_cfg_data[31:0]);
            endcase
        end
    end

    // frame and hop counters, and the phase accumulator
    always_comb begin
        cur_nb = eff_bands(r_cfg.num_bands);
        fl_eff = r_cfg.frame_length;
        if (fl_eff == 17'd0) begin
            fl_eff = 17'd1;
        end else if (fl_eff > FRAME_MAX) begin
            fl_eff = FRAME_MAX;
        end
        fl_m1   = fl_eff - 17'd1;
        band_p1 = {1'b0, r_band} + NB_BITS'(1);

        n_sample = r_sample;
        n_frame  = r_frame;
        n_band   = r_band;
        n_phase  = r_phase;
        if (i_adv) begin
            n_phase = r_phase + r_step;
            if ({1'b0, r_sample} >= fl_m1) begin
                n_sample = '0;
                if (r_frame >= r_cfg.hop_frames) begin
                    n_frame = '0;
                    // a band left beyond a lowered count wraps here too
                    n_band  = (band_p1 >= cur_nb) ? '0 : band_p1[BAND_BITS-1:0];
                end else begin
                    n_frame = r_frame + COUNT_BITS'(1);
                end
            end else begin
                n_sample = r_sample + COUNT_BITS'(1);
            end
        end
    end

    // phase increment for the band and config seen by the next item
    always_comb begin
        next_nb    = eff_bands(n_cfg.num_bands);
        next_nb_m1 = next_nb - NB_BITS'(1);
        offset     = signed'({1'b0, n_band, 1'b0}) - signed'({1'b0, next_nb_m1});
        step_prod  = offset * n_cfg.band_half_step;
        n_step     = step_prod[PHASE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= CFG_RESET;
            r_phase  <= '0;
            r_step   <= '0;
            r_sample <= '0;
            r_frame  <= '0;
            r_band   <= '0;
        end else begin
            r_cfg    <= n_cfg;
            r_phase  <= n_phase;
            r_step   <= n_step;
            r_sample <= n_sample;
            r_frame  <= n_frame;
            r_band   <= n_band;
        end
    end

    assign o_lut_idx = r_phase[PHASE_BITS-1 -: PHASE_LUT_BITS];
    assign o_band    = r_band;

    a_hold_without_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_phase) && $stable(r_sample) && $stable(r_frame)
                   && $stable(r_band))
        else $error("hop state moved without an item");

endmodule

[src/hopping_nco_mixer.sv]
// Frequency-hopping NCO mixer: rotates each complex sample by a running phase.
// Input channel: i_in_valid / o_in_ready carry one I/Q sample per item.
// Output channel: o_out_valid / i_out_ready carry the rotated, rounded and
// saturated sample plus the index of the band that rotated it.
// Configuration: i_cfg_wr_en writes i_cfg_data into the register at
// i_cfg_index (0 num_bands, 1 frame_length, 2 hop_frames, 3 band_half_step),
// taking effect from the next accepted item; write only while the block is idle.
// Pipeline: the three stages are the sine/cosine table read, the multiply, then
// round and saturate into the output register.
// Throughput is one item per cycle while the receiver keeps taking results, set by the single phase-accumulator add.
// When the receiver stalls, the stages ahead of the output register fill first
// and o_in_ready drops only once all three hold an item.
// Reset (synchronous, active low) restores the register defaults, clears the
// phase, frame and band counters and empties the pipeline.
module hopping_nco_mixer #(
    parameter int SAMPLE_BITS    = hnco_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_LUT_BITS = hnco_pkg::PHASE_LUT_BITS_DEF,
    parameter int MAX_BANDS      = hnco_pkg::MAX_BANDS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_wr_en,
    input  logic [hnco_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [hnco_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]           i_sample_i,
    input  logic signed [SAMPLE_BITS-1:0]           i_sample_q,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]           o_out_i,
    output logic signed [SAMPLE_BITS-1:0]           o_out_q,
    output logic [hnco_pkg::BAND_OUT_BITS-1:0]      o_band_used
);
    import hnco_pkg::*;

    localparam int BAND_BITS = $clog2(MAX_BANDS);
    localparam int PROD_BITS = SAMPLE_BITS + SINE_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;
    localparam int Q_BITS    = SUM_BITS - SINE_FRAC;
    localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1 << (SINE_FRAC - 1));
    localparam logic signed [Q_BITS-1:0]   SAT_HI     = Q_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Q_BITS-1:0]   SAT_LO     = Q_BITS'(-(1 << (SAMPLE_BITS - 1)));

    logic take1, take2, take3;
    logic in_acc;

    logic [PHASE_LUT_BITS-1:0]      lut_idx;
    logic [BAND_BITS-1:0]           cur_band;
    logic signed [SINE_BITS-1:0]    rom_sin, rom_cos;

    logic                           r_v1, r_v2, r_v3;
    logic signed [SAMPLE_BITS-1:0]  r_s1_i, r_s1_q;
    logic [BAND_BITS-1:0]           r_s1_band, r_s2_band;
    logic signed [PROD_BITS-1:0]    r_p_ic, r_p_qs, r_p_is, r_p_qc;
    logic signed [SAMPLE_BITS-1:0]  r_out_i, r_out_q;
    logic [BAND_OUT_BITS-1:0]       r_out_band;

    logic signed [SUM_BITS-1:0]     sum_i, sum_q;
    logic signed [SAMPLE_BITS-1:0]  n_out_i, n_out_q;
    logic [31:0]                    band_wide;

    // floor shift after the half-up offset, then clamp
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [SUM_BITS-1:0] acc
    );
        logic signed [Q_BITS-1:0] q;
        q = acc[SUM_BITS-1:SINE_FRAC];
        if (q > SAT_HI) begin
            q = SAT_HI;
        end else if (q < SAT_LO) begin
            q = SAT_LO;
        end
        return q[SAMPLE_BITS-1:0];
    endfunction

    // each stage loads when it is empty or the one after it moves on
    assign take3      = !r_v3 || i_out_ready;
    assign take2      = !r_v2 || take3;
    assign take1      = !r_v1 || take2;
    assign o_in_ready = take1;
    assign in_acc     = i_in_valid && take1;

    hnco_hop_ctrl #(
        .PHASE_LUT_BITS (PHASE_LUT_BITS),
        .MAX_BANDS      (MAX_BANDS)
    ) u_hop_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_adv       (in_acc),
        .o_lut_idx   (lut_idx),
        .o_band      (cur_band)
    );

    hnco_sine_rom #(
        .PHASE_LUT_BITS (PHASE_LUT_BITS)
    ) u_sine_rom (
        .i_clk   (i_clk),
        .i_rd_en (take1),
        .i_addr  (lut_idx),
        .o_sin   (rom_sin),
        .o_cos   (rom_cos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (take1) begin
                r_v1 <= in_acc;
            end
            if (take2) begin
                r_v2 <= r_v1;
            end
            if (take3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take1) begin
            r_s1_i    <= i_sample_i;
            r_s1_q    <= i_sample_q;
            r_s1_band <= cur_band;
        end
        if (take2) begin
            r_p_ic    <= r_s1_i * rom_cos;
            r_p_qs    <= r_s1_q * rom_sin;
            r_p_is    <= r_s1_i * rom_sin;
            r_p_qc    <= r_s1_q * rom_cos;
            r_s2_band <= r_s1_band;
        end
        if (take3) begin
            r_out_i    <= n_out_i;
            r_out_q    <= n_out_q;
            r_out_band <= band_wide[BAND_OUT_BITS-1:0];
        end
    end

    always_comb begin
        sum_i     = SUM_BITS'(r_p_ic) - SUM_BITS'(r_p_qs) + ROUND_HALF;
        sum_q     = SUM_BITS'(r_p_is) + SUM_BITS'(r_p_qc) + ROUND_HALF;
        n_out_i   = round_sat(sum_i);
        n_out_q   = round_sat(sum_q);
        band_wide = 32'(r_s2_band);
    end

    assign o_out_valid = r_v3;
    assign o_out_i     = r_out_i;
    assign o_out_q     = r_out_q;
    assign o_band_used = r_out_band;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_v1 && r_v2 && r_v3 && !i_out_ready)
        else $error("input stalled with a free stage");

    a_latency_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc ##1 i_out_ready ##1 i_out_ready |=> o_out_valid)
        else $error("item not at output after three cycles");

    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !r_v2 |=> !o_out_valid)
        else $error("output item appeared without a source");

endmodule

[tb/hopping_nco_mixer_tb.sv]
`timescale 1ns / 1ps

module hopping_nco_mixer_tb;
    import hnco_pkg::*;

    localparam int SB             = SAMPLE_BITS_DEF;
    localparam int LUT_BITS       = PHASE_LUT_BITS_DEF;
    localparam int LUT_SIZE       = 1 << LUT_BITS;
    localparam int BANDS_MAX      = MAX_BANDS_DEF;
    localparam int Q30            = 30;
    localparam int IDLE_PCT       = 14;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int NUM_CORNERS    = 12;
    localparam int MAX_REPORTS    = 40;

    localparam int CORNER_I [NUM_CORNERS] =
        '{32767, -32768, 32767, -32768, 0, -1, 1, 0, -32768, 0, 16384, 32767};
    localparam int CORNER_Q [NUM_CORNERS] =
        '{32767, -32768, -32768, 32767, 0, -1, 0, 1, 0, -32768, -16384, 0};

    typedef struct {
        logic signed [SB-1:0]     out_i;
        logic signed [SB-1:0]     out_q;
        logic [BAND_OUT_BITS-1:0] band;
    } t_rotated;

    class mixer_scoreboard;
        t_hop_cfg                regs;
        bit [PHASE_BITS-1:0]     phase;
        bit [COUNT_BITS-1:0]     smp_in_frame;
        bit [COUNT_BITS-1:0]     frames_done;
        bit [BAND_OUT_BITS-1:0]  band;
        int                      sine_lut [LUT_SIZE];
        t_rotated                rotated_q [$];
        int                      errors;
        int                      compared;

        function new();
            bit [63:0] x, mag, sum, amp;
            int sv, quarter;
            regs = CFG_RESET;
            phase = '0;
            smp_in_frame = '0;
            frames_done = '0;
            band = '0;
            errors = 0;
            compared = 0;
            // first quarter from a truncated taylor series, the rest by symmetry
            quarter = LUT_SIZE / 4;
            for (int k = 0; k <= quarter; k++) begin
                x = (64'(k) * HALF_PI_Q30 + 64'(quarter / 2)) / 64'(quarter);
                sum = x;
                mag = x;
                for (int n = 1; n <= TAYLOR_TERMS; n++) begin
                    mag = (mag * x) >> Q30;
                    mag = (mag * x) >> Q30;
                    mag = mag / 64'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1)
                        sum = (sum >= mag) ? sum - mag : 64'd0;
                    else
                        sum = sum + mag;
                end
                amp = (sum * SINE_AMP + (64'd1 << (Q30 - 1))) >> Q30;
                sv = (amp > SINE_AMP) ? int'(SINE_AMP) : int'(amp);
                sine_lut[k % LUT_SIZE] = sv;
                sine_lut[(LUT_SIZE / 2 - k) % LUT_SIZE] = sv;
                sine_lut[(LUT_SIZE / 2 + k) % LUT_SIZE] = -sv;
                sine_lut[(LUT_SIZE - k) % LUT_SIZE] = -sv;
            end
        endfunction

        function void set_reg(t_cfg_reg idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_NUM_BANDS:      regs.num_bands = data[4:0];
                CFG_FRAME_LENGTH:   regs.frame_length = data[16:0];
                CFG_HOP_FRAMES:     regs.hop_frames = data[15:0];
                CFG_BAND_HALF_STEP: regs.band_half_step = data;
                default: ;
            endcase
        endfunction

        function logic signed [SB-1:0] round_sat(longint acc);
            longint q, hi;
            hi = (longint'(1) <<< (SB - 1)) - 1;
            q = (acc + (longint'(1) <<< (SINE_FRAC - 1))) >>> SINE_FRAC;
            if (q > hi) q = hi;
            if (q < -hi - 1) q = -hi - 1;
            return q[SB-1:0];
        endfunction

        function void note_sample(logic signed [SB-1:0] si, logic signed [SB-1:0] sq);
            int nb, fl, ix, off;
            longint sn, cs;
            bit [PHASE_BITS-1:0] step;
            t_rotated r;
            nb = int'(regs.num_bands);
            if (nb == 0) nb = 1;
            if (nb > BANDS_MAX) nb = BANDS_MAX;
            fl = int'(regs.frame_length);
            if (fl == 0) fl = 1;
            if (fl > int'(FRAME_MAX)) fl = int'(FRAME_MAX);

            ix = int'(phase >> (PHASE_BITS - LUT_BITS));
            sn = sine_lut[ix];
            cs = sine_lut[(ix + LUT_SIZE / 4) % LUT_SIZE];
            r.out_i = round_sat(longint'(si) * cs - longint'(sq) * sn);
            r.out_q = round_sat(longint'(si) * sn + longint'(sq) * cs);
            r.band = band;
            rotated_q.push_back(r);

            // a band left above the count after a shrink still sets the step
            off = 2 * int'(band) - (nb - 1);
            step = 32'(off) * 32'(regs.band_half_step);
            phase = phase + step;

            if (int'(smp_in_frame) >= fl - 1) begin
                smp_in_frame = '0;
                if (frames_done >= regs.hop_frames) begin
                    frames_done = '0;
                    band = (int'(band) + 1 >= nb) ? '0 : band + 1'b1;
                end else begin
                    frames_done = frames_done + 1'b1;
                end
            end else begin
                smp_in_frame = smp_in_frame + 1'b1;
            end
        endfunction

        task report_mismatch(string field, longint got, longint want);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("result %0d: %s is %0d, predicted %0d", compared, field, got, want);
        endtask

        task check_rotated(logic signed [SB-1:0] oi, logic signed [SB-1:0] oq,
                           logic [BAND_OUT_BITS-1:0] bu);
            t_rotated want;
            compared++;
            if (rotated_q.size() == 0) begin
                report_mismatch("out_i with no sample outstanding", oi, 0);
                return;
            end
            want = rotated_q.pop_front();
            if (oi !== want.out_i) report_mismatch("out_i", oi, want.out_i);
            if (oq !== want.out_q) report_mismatch("out_q", oq, want.out_q);
            if (bu !== want.band) report_mismatch("band_used", bu, want.band);
        endtask
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_wr_en = 1'b0;
    t_cfg_reg                 i_cfg_index = CFG_NUM_BANDS;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic signed [SB-1:0]     i_sample_i = '0;
    logic signed [SB-1:0]     i_sample_q = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [SB-1:0]     o_out_i;
    logic signed [SB-1:0]     o_out_q;
    logic [BAND_OUT_BITS-1:0] o_band_used;

    mixer_scoreboard sb = new();
    int n_taken = 0;
    int n_setups = 0;
    int stall_cycles = 0;
    bit gaps_on = 1'b1;
    bit hold_req = 1'b0;

    hopping_nco_mixer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample_i  (i_sample_i),
        .i_sample_q  (i_sample_q),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_i     (o_out_i),
        .o_out_q     (o_out_q),
        .o_band_used (o_band_used)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.note_sample(i_sample_i, i_sample_q);
                n_taken++;
            end
            if (o_out_valid && i_out_ready)
                sb.check_rotated(o_out_i, o_out_q, o_band_used);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    function automatic logic signed [SB-1:0] rand_sample();
        case ($urandom_range(15))
            0: return {1'b0, {(SB - 1){1'b1}}};
            1: return {1'b1, {(SB - 1){1'b0}}};
            default: return SB'($urandom);
        endcase
    endfunction

    task automatic send_item(logic signed [SB-1:0] si, logic signed [SB-1:0] sq);
        int target;
        target = n_taken + 1;
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_i <= si;
        i_sample_q <= sq;
        @(negedge i_clk);
        while (n_taken != target) @(negedge i_clk);
    endtask

    task automatic send_random(int count);
        for (int k = 0; k < count; k++)
            send_item(rand_sample(), rand_sample());
    endtask

    task automatic send_corners();
        for (int k = 0; k < NUM_CORNERS; k++)
            send_item(SB'(CORNER_I[k]), SB'(CORNER_Q[k]));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.rotated_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic apply_cfg(logic [31:0] nb_w, logic [31:0] fl_w, logic [31:0] hf_w,
                             logic [31:0] hs_w);
        write_reg(CFG_NUM_BANDS, nb_w);
        write_reg(CFG_FRAME_LENGTH, fl_w);
        write_reg(CFG_HOP_FRAMES, hf_w);
        write_reg(CFG_BAND_HALF_STEP, hs_w);
        i_cfg_wr_en <= 1'b0;
        n_setups++;
    endtask

    // mode flags change on a rising edge so the receiver sees them cleanly
    task automatic set_mode(bit gaps, bit hold);
        @(posedge i_clk);
        gaps_on = gaps;
        hold_req = hold;
        @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] nb_w, fl_w, hf_w, hs_w;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset registers: zero step, so the rotator stays at a phase of zero
        send_corners();
        drain();

        // half steps of an eighth turn give 45 degree multiples that saturate the corners
        apply_cfg(32'd4, 32'd1, 32'd0, 32'h2000_0000);
        send_corners();
        drain();

        // hop every sample over all bands, stopping on a high band
        apply_cfg(32'd16, 32'd1, 32'd0, $urandom);
        send_random((13 - int'(sb.band) + BANDS_MAX) % BANDS_MAX + 2 * BANDS_MAX);
        drain();

        // fewer bands than the current index
        apply_cfg(32'd3, 32'd2, 32'd0, $urandom);
        send_random(20);
        drain();

        // zero bands and zero frame length
        apply_cfg(32'd0, 32'd0, 32'd0, 32'h8000_0000);
        send_random(20);
        drain();

        // counts clamped at their ceilings, largest positive step
        apply_cfg(32'd31, 32'h1_FFFF, 32'hFFFF, 32'h7FFF_FFFF);
        send_random(40);
        drain();

        // frame length shrunk below the running sample count
        apply_cfg(32'd5, 32'd3, 32'hFFFF, 32'hFFFF_FFFF);
        send_random(40);
        drain();

        // hop count shrunk below the running frame count, zero step
        apply_cfg(32'd5, 32'd1, 32'd2, 32'd0);
        send_random(20);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            nb_w = ($urandom_range(7) == 0) ? $urandom_range(0, 31)
                                             : $urandom_range(1, BANDS_MAX);
            fl_w = ($urandom_range(5) == 0) ? $urandom_range(0, 131071)
                                             : $urandom_range(1, 12);
            hf_w = ($urandom_range(5) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 3);
            hs_w = $urandom;
            // junk above each register's width should be dropped
            if ($urandom_range(1)) begin
                nb_w = nb_w | ($urandom & ~32'h1F);
                fl_w = fl_w | ($urandom & ~32'h1_FFFF);
                hf_w = hf_w | ($urandom & ~32'hFFFF);
            end
            apply_cfg(nb_w, fl_w, hf_w, hs_w);
            set_mode(p != 3, p == 1);
            send_random($urandom_range(95, 125));
            drain();
        end

        repeat (10) @(negedge i_clk);
        $display("rotated %0d samples under %0d register setups, with hops, band shrinks,",
                 n_taken, n_setups);
        $display("clamped counts, a long output hold-off and %0d results compared",
                 sb.compared);
        if (sb.errors == 0 && sb.rotated_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
